// ----- rtl/core/biv_pkg.sv -----
// biv_pkg: shared types, constants and the CRC-32 byte step for the boot
// image validator. No dependencies; every other file in rtl/core imports it.
`timescale 1ns / 1ps

package biv_pkg;

  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
  localparam logic [31:0] MIN_IMAGE_BYTES = 32'd8;

  // Register reset values
  localparam logic [31:0] SRAM_LOW_RST     = 32'h2000_0000;
  localparam logic [31:0] SRAM_HIGH_RST    = 32'h2001_3FFF;
  localparam logic [31:0] CODE_BASE_RST    = 32'h0801_0000;
  localparam logic [31:0] MAX_BYTES_RST    = 32'd65536;
  localparam logic [31:0] EXP_CRC_RST      = 32'hFFFF_FFFF;
  localparam logic [31:0] SRC_ADDR_RST     = 32'h0801_0000;
  localparam logic        CHECK_SOURCE_RST = 1'b1;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRAM_LOW     = 3'd0,
    CFG_SRAM_HIGH    = 3'd1,
    CFG_CODE_BASE    = 3'd2,
    CFG_MAX_BYTES    = 3'd3,
    CFG_EXPECTED_CRC = 3'd4,
    CFG_SOURCE_ADDR  = 3'd5,
    CFG_CHECK_SOURCE = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    REASON_OK     = 3'd0,
    REASON_SOURCE = 3'd1,
    REASON_SIZE   = 3'd2,
    REASON_STACK  = 3'd3,
    REASON_VECTOR = 3'd4,
    REASON_CRC    = 3'd5
  } fail_reason_e;

  // Reflected CRC-32, one byte: eight shift/xor steps.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/biv_if.sv -----
// Valid/ready channel interfaces for the boot image validator: image bytes,
// verdicts and register writes. Depends on biv_pkg.
`timescale 1ns / 1ps

interface biv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface biv_out_if;
  logic        valid;
  logic        ready;
  logic        image_valid;
  logic [2:0]  fail_reason;
  logic [31:0] computed_crc;

  modport source (output valid, output image_valid, output fail_reason,
                  output computed_crc, input ready);
  modport sink   (input valid, input image_valid, input fail_reason,
                  input computed_crc, output ready);
endinterface

interface biv_cfg_if;
  import biv_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/boot_image_validator.sv -----
// boot_image_validator: streams one image byte per cycle; after the last byte
// is accepted, the result moves through the verdict register, then the output register.
// Throughput: one byte per cycle; in_i.ready drops only while a verdict is
// parked in the first stage and the output register is full and stalled.
// Reset (rst_ni low, async): registers to defaults, CRC to all ones, count
// and vector-table words to zero, no result pending. No clearing pass.
`timescale 1ns / 1ps

module boot_image_validator (
  input  logic    clk_i,
  input  logic    rst_ni,
  biv_in_if.sink  in_i,
  biv_cfg_if.sink cfg_i,
  biv_out_if.source res_o
);
  import biv_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes are always taken; software must only write
  // while no image is in flight, which the block itself does not enforce.
  // ---------------------------------------------------------------------
  logic [31:0] sram_low_q, sram_high_q, code_base_q, max_bytes_q;
  logic [31:0] exp_crc_q, src_addr_q;
  logic        check_src_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sram_low_q  <= SRAM_LOW_RST;
      sram_high_q <= SRAM_HIGH_RST;
      code_base_q <= CODE_BASE_RST;
      max_bytes_q <= MAX_BYTES_RST;
      exp_crc_q   <= EXP_CRC_RST;
      src_addr_q  <= SRC_ADDR_RST;
      check_src_q <= CHECK_SOURCE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SRAM_LOW:     sram_low_q  <= cfg_i.data;
        CFG_SRAM_HIGH:    sram_high_q <= cfg_i.data;
        CFG_CODE_BASE:    code_base_q <= cfg_i.data;
        CFG_MAX_BYTES:    max_bytes_q <= cfg_i.data;
        CFG_EXPECTED_CRC: exp_crc_q   <= cfg_i.data;
        CFG_SOURCE_ADDR:  src_addr_q  <= cfg_i.data;
        CFG_CHECK_SOURCE: check_src_q <= cfg_i.data[0];
        default: ;  // unused index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control
  //   stage 1: running state (CRC, count, stack/vector words); on the last
  //            byte the finished image summary moves into the verdict regs
  //   stage 2: checks, into the output register
  // ---------------------------------------------------------------------
  logic s1_valid_q, out_valid_q;
  logic s1_move, s1_free, in_fire;

  assign s1_move = s1_valid_q && (!out_valid_q || res_o.ready);
  assign s1_free = !s1_valid_q || s1_move;
  assign in_i.ready = s1_free;
  assign in_fire = in_i.valid && s1_free;

  // ---------------------------------------------------------------------
  // Stage 1: per-byte update
  // ---------------------------------------------------------------------
  logic [31:0] crc_q, cnt_q, sp_q, rv_q;
  logic [31:0] crc_d, cnt_d, sp_d, rv_d;
  logic [4:0]  lane_sh;

  assign lane_sh = {cnt_q[1:0], 3'b000};

  always_comb begin
    crc_d = crc32_byte(crc_q, in_i.data_byte);
    cnt_d = (cnt_q != ALL_ONES) ? cnt_q + 32'd1 : cnt_q;  // saturating
    sp_d  = sp_q;
    rv_d  = rv_q;
    // bytes 0..3: stack pointer, bytes 4..7: reset vector (little-endian)
    if (cnt_q[31:2] == 30'd0) begin
      sp_d[lane_sh +: 8] = sp_q[lane_sh +: 8] | in_i.data_byte;
    end else if (cnt_q[31:3] == 29'd0) begin
      rv_d[lane_sh +: 8] = rv_q[lane_sh +: 8] | in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= ALL_ONES;
      cnt_q <= '0;
      sp_q  <= '0;
      rv_q  <= '0;
    end else if (in_fire) begin
      if (in_i.last_byte) begin
        // verdict taken; start fresh for the next image
        crc_q <= ALL_ONES;
        cnt_q <= '0;
        sp_q  <= '0;
        rv_q  <= '0;
      end else begin
        crc_q <= crc_d;
        cnt_q <= cnt_d;
        sp_q  <= sp_d;
        rv_q  <= rv_d;
      end
    end
  end

  // Verdict stage registers
  logic [31:0] s1_size_q, s1_crc_q, s1_sp_q, s1_rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire && in_i.last_byte) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.last_byte) begin
      s1_size_q <= cnt_d;
      s1_crc_q  <= ~crc_d;
      s1_sp_q   <= sp_d;
      s1_rv_q   <= rv_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: checks in priority order, first failure wins
  // ---------------------------------------------------------------------
  logic [32:0]  image_end;
  logic [31:0]  entry_addr;
  fail_reason_e reason;

  assign image_end  = {1'b0, code_base_q} + {1'b0, s1_size_q};  // no wrap
  assign entry_addr = {s1_rv_q[31:1], 1'b0};

  always_comb begin
    priority if (check_src_q && (src_addr_q != code_base_q)) begin
      reason = REASON_SOURCE;
    end else if ((s1_size_q < MIN_IMAGE_BYTES) || (s1_size_q > max_bytes_q)) begin
      reason = REASON_SIZE;
    end else if ((s1_sp_q < sram_low_q) || (s1_sp_q > sram_high_q) ||
                 (s1_sp_q[1:0] != 2'b00)) begin
      reason = REASON_STACK;
    end else if (!s1_rv_q[0] || (entry_addr < code_base_q) ||
                 ({1'b0, entry_addr} >= image_end)) begin
      reason = REASON_VECTOR;  // thumb bit clear or entry outside image
    end else if ((exp_crc_q != ALL_ONES) && (s1_crc_q != exp_crc_q)) begin
      reason = REASON_CRC;
    end else begin
      reason = REASON_OK;
    end
  end

  // Output register
  fail_reason_e reason_q;
  logic [31:0]  crc_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      reason_q  <= reason;
      crc_out_q <= s1_crc_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.image_valid  = (reason_q == REASON_OK);
  assign res_o.fail_reason  = reason_q;
  assign res_o.computed_crc = crc_out_q;

endmodule

// ----- sim/boot_image_validator_tb.sv -----
`timescale 1ns / 1ps
// boot_image_validator_tb: self-checking bench for the boot image validator.
// Depends on biv_pkg, the biv_in_if / biv_out_if / biv_cfg_if interfaces and
// the RTL top; streams images under random handshake gaps and checks verdicts.

module boot_image_validator_tb;
  import biv_pkg::*;

  localparam int unsigned TARGET_BYTES = 850;  // random byte requests after the directed set
  localparam int unsigned IDLE_PCT     = 28;   // chance per cycle that a side idles
  localparam int unsigned HOLD_CYCLES  = 160;  // long output hold-off in the pressure phase
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned STEADY_PHASE = 3;    // no idling on either side
  localparam int unsigned SQUEEZE_PHASE = 2;   // output held off, input backs up
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } img_byte_t;

  typedef struct packed {
    logic         ok;
    fail_reason_e reason;
    logic [31:0]  crc;
  } verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  biv_in_if  in_if ();
  biv_out_if res_if ();
  biv_cfg_if cfg_if ();

  boot_image_validator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register shadows plus the per-image accumulators.
  // ---------------------------------------------------------------------------
  logic [31:0] sram_lo_q, sram_hi_q, code_base_q, max_bytes_q, exp_crc_q, src_addr_q;
  logic        check_src_q;
  logic [31:0] crc_run, byte_cnt, sp_word, rv_word;
  verdict_t    verdict_q[$];      // verdicts still owed by the block

  // Stimulus: staged image bytes move to byte_q once the registers are set.
  img_byte_t   stage_q[$];
  img_byte_t   byte_q[$];
  int unsigned staged_bytes = 0;

  // Handshake bookkeeping shared between the clocked processes.
  bit          in_fired  = 1'b0;  // byte request taken at the last rising edge
  bit          steady    = 1'b0;  // suppress random idling on both sides
  bit          hold_req  = 1'b0;  // ask the receiver for one long hold-off
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned mismatches     = 0;
  int unsigned images_checked = 0;
  int unsigned reason_seen[6] = '{default: 0};

  // Reflected CRC-32 over one byte, bit-serial: feedback is LSB xor data bit.
  function automatic logic [31:0] crc32_next(logic [31:0] acc, logic [7:0] b);
    logic [31:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ b[i]) ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  function automatic void restart_image();
    crc_run  = ALL_ONES;
    byte_cnt = 32'd0;
    sp_word  = 32'd0;
    rv_word  = 32'd0;
  endfunction

  // Checks run in priority order; the first failing one names the reason.
  function automatic fail_reason_e judge_image(logic [31:0] size, logic [31:0] crc);
    logic [31:0] addr;
    logic [32:0] lim;
    if (check_src_q && src_addr_q != code_base_q) return REASON_SOURCE;
    if (size < MIN_IMAGE_BYTES || size > max_bytes_q) return REASON_SIZE;
    if (sp_word < sram_lo_q || sp_word > sram_hi_q || sp_word[1:0] != 2'b00)
      return REASON_STACK;
    if (!rv_word[0]) return REASON_VECTOR;
    addr = {rv_word[31:1], 1'b0};
    lim  = {1'b0, code_base_q} + {1'b0, size};  // 33 bits: end of image never wraps
    if (addr < code_base_q || {1'b0, addr} >= lim) return REASON_VECTOR;
    if (exp_crc_q != ALL_ONES && crc != exp_crc_q) return REASON_CRC;
    return REASON_OK;
  endfunction

  // Fold one accepted byte request into the image; the last byte yields a verdict.
  function automatic void fold_byte(logic [7:0] b, logic last);
    verdict_t v;
    if (byte_cnt < 4) begin
      sp_word |= {24'd0, b} << (8 * byte_cnt);
    end else if (byte_cnt < 8) begin
      rv_word |= {24'd0, b} << (8 * (byte_cnt - 4));
    end
    crc_run = crc32_next(crc_run, b);
    if (byte_cnt != ALL_ONES) byte_cnt++;  // count saturates
    if (last) begin
      v.crc    = ~crc_run;
      v.reason = judge_image(byte_cnt, v.crc);
      v.ok     = (v.reason == REASON_OK);
      verdict_q.push_back(v);
      restart_image();
    end
  endfunction

  // Build an image with the given vector-table words (as far as len reaches)
  // and random payload; returns its final CRC.
  function automatic logic [31:0] stage_image(logic [31:0] sp, logic [31:0] rv,
                                              int unsigned len);
    img_byte_t   ib;
    logic [31:0] acc;
    acc = ALL_ONES;
    for (int unsigned i = 0; i < len; i++) begin
      if (i < 4) ib.data = sp[8*i +: 8];
      else if (i < 8) ib.data = rv[8*(i-4) +: 8];
      else ib.data = 8'($urandom);
      ib.last = (i == len - 1);
      acc = crc32_next(acc, ib.data);
      stage_q.push_back(ib);
    end
    staged_bytes += len;
    return ~acc;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: one rising-edge process checks verdicts, then predicts from
  // the register and byte requests taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    verdict_t want;
    in_fired = rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: verdict with none pending: valid=%0b reason=%0d crc=%h",
                   $realtime, res_if.image_valid, res_if.fail_reason, res_if.computed_crc);
      end else begin
        want = verdict_q.pop_front();
        images_checked++;
        reason_seen[want.reason]++;
        if (res_if.image_valid !== want.ok || res_if.fail_reason !== want.reason ||
            res_if.computed_crc !== want.crc) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: verdict mismatch: valid %0b/%0b reason %0d/%0d crc %h/%h (exp/act)",
                     $realtime, want.ok, res_if.image_valid, want.reason,
                     res_if.fail_reason, want.crc, res_if.computed_crc);
        end
      end
    end
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        CFG_SRAM_LOW:     sram_lo_q   = cfg_if.data;
        CFG_SRAM_HIGH:    sram_hi_q   = cfg_if.data;
        CFG_CODE_BASE:    code_base_q = cfg_if.data;
        CFG_MAX_BYTES:    max_bytes_q = cfg_if.data;
        CFG_EXPECTED_CRC: exp_crc_q   = cfg_if.data;
        CFG_SOURCE_ADDR:  src_addr_q  = cfg_if.data;
        CFG_CHECK_SOURCE: check_src_q = cfg_if.data[0];
        default: ;  // unmapped index: write is dropped
      endcase
    end
    if (in_fired) fold_byte(in_if.data_byte, in_if.last_byte);
  end

  // Byte driver: on the falling edge, hold the current request until taken,
  // then offer the next pending byte or idle at random.
  always @(negedge clk_i) begin : feeder
    img_byte_t nxt;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= 8'd0;
      in_if.last_byte <= 1'b0;
    end else if (!in_if.valid || in_fired) begin
      if (byte_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = byte_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.data_byte <= nxt.data;
        in_if.last_byte <= nxt.last;
      end else begin
        in_if.valid     <= 1'b0;
        in_if.data_byte <= 8'($urandom);
      end
    end
  end

  // Verdict receiver: random back-pressure, plus one long hold-off on request.
  always @(negedge clk_i) begin : drain
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Register write request; valid stays high so writes can run back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
  endtask

  // Wait for the block to go idle: all bytes taken and all verdicts back.
  task automatic settle();
    while (byte_q.size() != 0 || in_if.valid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer: directed images on reset settings, then random phases, each
  // with a fresh register set written while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int unsigned     phase, n_img, len, pick, stop_at, kind;
    logic [31:0]     sp, rv;
    logic [31:0]     plan_lo, plan_hi, plan_base, plan_max, plan_crc, plan_src;
    logic            plan_check;
    logic [31:0]     crc_list[$];
    longint unsigned span;

    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_SRAM_LOW;
    cfg_if.data     = 32'd0;

    sram_lo_q   = SRAM_LOW_RST;
    sram_hi_q   = SRAM_HIGH_RST;
    code_base_q = CODE_BASE_RST;
    max_bytes_q = MAX_BYTES_RST;
    exp_crc_q   = EXP_CRC_RST;
    src_addr_q  = SRC_ADDR_RST;
    check_src_q = CHECK_SOURCE_RST;
    restart_image();

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings: a passing image at the top of SRAM with the
    // reset vector on the last code byte, a one-byte image, an unaligned
    // stack pointer, and a reset vector without the thumb bit.
    void'(stage_image(SRAM_HIGH_RST & ~32'h3, (CODE_BASE_RST + 32'd7) | 32'd1, 8));
    void'(stage_image(ALL_ONES, 32'd0, 1));
    void'(stage_image(SRAM_LOW_RST | 32'h2, CODE_BASE_RST | 32'd1, 8));
    void'(stage_image(SRAM_LOW_RST, CODE_BASE_RST, 8));
    byte_q = stage_q;
    stage_q.delete();
    settle();

    stop_at = staged_bytes + TARGET_BYTES;
    phase   = 0;
    while (staged_bytes < stop_at) begin
      phase++;

      // SRAM window: reset, full range, inverted, a single word, or random.
      case ($urandom_range(5))
        0: begin plan_lo = SRAM_LOW_RST; plan_hi = SRAM_HIGH_RST; end
        1: begin plan_lo = 32'd0; plan_hi = ALL_ONES; end
        2: begin plan_lo = ($urandom & ~32'h3) | 32'h10; plan_hi = plan_lo - 32'd4; end
        3: begin plan_lo = $urandom & ~32'h3; plan_hi = plan_lo; end
        default: begin
          plan_lo = $urandom & ~32'h3;
          plan_hi = plan_lo + $urandom_range(4096);
          if (plan_hi < plan_lo) plan_hi = ALL_ONES;
        end
      endcase

      // Code base near the top of the space exercises the non-wrapping end.
      case ($urandom_range(5))
        0, 1: plan_base = CODE_BASE_RST;
        2:    plan_base = 32'd0;
        3:    plan_base = 32'hFFFF_FFF0;
        4:    plan_base = $urandom & ~32'h3;
        default: plan_base = $urandom;
      endcase

      case ($urandom_range(9))
        0: plan_max = MIN_IMAGE_BYTES;
        1: plan_max = ALL_ONES;
        2: plan_max = $urandom_range(7);  // below the minimum size: all fail
        3: plan_max = MAX_BYTES_RST;
        default: plan_max = $urandom_range(8, 40);
      endcase

      // Primary slot mostly; sometimes a wrong source, sometimes backup mode.
      pick       = $urandom_range(9);
      plan_check = (pick < 8);
      plan_src   = (pick < 7) ? plan_base : $urandom;

      crc_list.delete();
      if (phase == SQUEEZE_PHASE) begin
        // Many tiny images so verdicts pile up behind the held-off receiver.
        for (int i = 0; i < 18; i++) begin
          crc_list.push_back(stage_image($urandom, $urandom, $urandom_range(1, 3)));
        end
      end else begin
        n_img = (phase == STEADY_PHASE) ? 14 : $urandom_range(2, 6);
        for (int i = 0; i < n_img; i++) begin
          len = $urandom_range(8, 24);
          if ($urandom_range(9) == 0) len = $urandom_range(25, 96);
          if (plan_max < 64 && $urandom_range(3) == 0) len = plan_max + $urandom_range(1);
          if (len == 0) len = 1;

          if (plan_hi >= plan_lo) begin
            span = {32'd0, plan_hi} - {32'd0, plan_lo} + 64'd1;
            sp   = 32'(plan_lo + ({$urandom, $urandom} % span)) & ~32'h3;
          end else begin
            sp = plan_lo;
          end
          rv = (plan_base + $urandom_range(len - 1)) | 32'd1;

          kind = $urandom_range(99);
          if (kind >= 95) begin
            sp = $urandom;  // noise image
            rv = $urandom;
            len = $urandom_range(1, 40);
          end else if (kind >= 91) begin
            len = $urandom_range(1, 7);  // too short to hold a vector table
          end else if (kind >= 83) begin
            case ($urandom_range(2))
              0: rv = rv & ~32'd1;
              1: rv = (plan_base + len + $urandom_range(64)) | 32'd1;
              default: rv = (plan_base - 32'd2) | 32'd1;
            endcase
          end else if (kind >= 75) begin
            case ($urandom_range(2))
              0: sp = plan_lo - 32'd4;
              1: sp = (plan_hi & ~32'h3) + 32'd4;
              default: sp = sp | 32'h2;
            endcase
          end
          crc_list.push_back(stage_image(sp, rv, len));
        end
      end

      // Expected CRC: skip, match one image of the phase, or random.
      case ($urandom_range(9))
        0, 1, 2: plan_crc = crc_list[$urandom_range(crc_list.size() - 1)];
        3:       plan_crc = $urandom;
        default: plan_crc = ALL_ONES;
      endcase

      if ($urandom_range(3) == 0) write_reg(CFG_UNMAPPED, $urandom);
      write_reg(CFG_SRAM_LOW, plan_lo);
      write_reg(CFG_SRAM_HIGH, plan_hi);
      write_reg(CFG_CODE_BASE, plan_base);
      write_reg(CFG_MAX_BYTES, plan_max);
      write_reg(CFG_EXPECTED_CRC, plan_crc);
      write_reg(CFG_SOURCE_ADDR, plan_src);
      write_reg(CFG_CHECK_SOURCE, {31'd0, plan_check});
      @(negedge clk_i);
      cfg_if.valid <= 1'b0;
      @(posedge clk_i);

      steady   = (phase == STEADY_PHASE);
      hold_req = hold_req || (phase == SQUEEZE_PHASE);
      byte_q   = stage_q;
      stage_q.delete();
      settle();
      steady = 1'b0;
    end

    repeat (8) @(posedge clk_i);
    $display("boot_image_validator_tb: %0d images, %0d bytes, %0d register settings, %0d mismatches",
             images_checked, staged_bytes, phase, mismatches);
    $display("  verdicts by reason: ok %0d, source %0d, size %0d, stack %0d, vector %0d, crc %0d",
             reason_seen[REASON_OK], reason_seen[REASON_SOURCE], reason_seen[REASON_SIZE],
             reason_seen[REASON_STACK], reason_seen[REASON_VECTOR], reason_seen[REASON_CRC]);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("boot_image_validator_tb: PASS");
    end else begin
      $display("boot_image_validator_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("boot_image_validator_tb: FAIL");
    $finish;
  end

endmodule
